>>> sv/fbfl_pkg.sv
// shared types and constants of the fixed-size block free-list allocator
package fbfl_pkg;

  localparam int CMD_W = 2;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int STS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd2;
  localparam logic [STS_W-1:0] STS_BAD   = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX     = 11'd2047;
  localparam logic [CNT_W-1:0] BLK_CNT_RST = 11'd1024;
  localparam int               RST_COUNT   = 1024;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep_wr;
    logic commit;
  } fbfl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_clear;
    logic sweep_last;
    logic out_free;
  } fbfl_stat_t;

endpackage

>>> sv/fbfl_ctrl.sv
// sequencer of the allocator: reset pass, accept, relink sweep, commit
module fbfl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fbfl_pkg::fbfl_stat_t stat_i,
  output fbfl_pkg::fbfl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_RST_SWEEP,
    ST_IDLE,
    ST_SWEEP,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.sweep_wr = (state_q == ST_RST_SWEEP) || (state_q == ST_SWEEP);
    cmd_o.commit   = (state_q == ST_EXEC) && stat_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RST_SWEEP: if (stat_i.sweep_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) state_d = stat_i.in_clear ? ST_SWEEP : ST_EXEC;
      end
      ST_SWEEP: if (stat_i.sweep_last) state_d = ST_EXEC;
      ST_EXEC: if (stat_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RST_SWEEP;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = rdy_q;

endmodule

>>> sv/fbfl_dp.sv
// datapath: link store, list head, use count, relink sweep and result register
module fbfl_dp #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fbfl_pkg::fbfl_cmd_t              cmd_i,
  output fbfl_pkg::fbfl_stat_t             stat_o,
  input  logic [fbfl_pkg::CMD_W-1:0]       in_cmd_i,
  input  logic [fbfl_pkg::IDX_W-1:0]       in_idx_i,
  input  logic                            cfg_valid_i,
  input  logic [fbfl_pkg::CNT_W-1:0]       cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [fbfl_pkg::STS_W-1:0]       out_status_o,
  output logic [fbfl_pkg::IDX_W-1:0]       out_idx_o,
  output logic [fbfl_pkg::CNT_W-1:0]       out_cnt_o
);

  localparam int IW     = $clog2(MAX_BLOCKS);
  localparam int CW     = $clog2(MAX_BLOCKS + 1);
  localparam int UW     = (CW > fbfl_pkg::CNT_W) ? CW : fbfl_pkg::CNT_W;
  localparam int RstCnt = (MAX_BLOCKS < fbfl_pkg::RST_COUNT) ? MAX_BLOCKS
                                                              : fbfl_pkg::RST_COUNT;

  logic [fbfl_pkg::CNT_W-1:0] blk_cnt_q;
  logic [fbfl_pkg::CMD_W-1:0] cmd_q;
  logic [fbfl_pkg::IDX_W-1:0] idx_q;
  logic [IW-1:0]              head_q, head_d;
  logic                       empty_q, empty_d;
  logic [fbfl_pkg::CNT_W-1:0] inuse_q, inuse_d;
  logic [IW-1:0]              swp_q;
  logic [UW-1:0]              swp_cnt_q;
  logic [IW:0]                rd_q;
  logic [IW:0]                link_mem [MAX_BLOCKS];

  logic                       out_valid_q;
  logic [fbfl_pkg::STS_W-1:0] out_status_q, sts_d;
  logic [fbfl_pkg::IDX_W-1:0] out_idx_q, given_d;
  logic [fbfl_pkg::CNT_W-1:0] out_cnt_q;

  logic [UW-1:0] bc_ext, used;
  logic          in_range;
  logic [UW-1:0] swp_nxt;
  logic [IW:0]   wr_data;
  logic [IW-1:0] wr_addr;
  logic          wr_en;

  // effective pool size, clamped to 1..MAX_BLOCKS
  always_comb begin
    bc_ext = UW'(blk_cnt_q);
    if (bc_ext == '0) used = UW'(1);
    else if (bc_ext > UW'(MAX_BLOCKS)) used = UW'(MAX_BLOCKS);
    else used = bc_ext;
  end

  assign in_range = UW'(idx_q) < used;
  assign swp_nxt  = UW'(swp_q) + UW'(1);

  always_comb begin
    head_d  = head_q;
    empty_d = empty_q;
    inuse_d = inuse_q;
    sts_d   = fbfl_pkg::STS_OK;
    given_d = '0;
    case (cmd_q)
      fbfl_pkg::CMD_ALLOC: begin
        if (empty_q) begin
          sts_d = fbfl_pkg::STS_EMPTY;
        end else begin
          given_d = fbfl_pkg::IDX_W'(head_q);
          if (rd_q[IW]) empty_d = 1'b1;
          else head_d = rd_q[IW-1:0];
          if (inuse_q < fbfl_pkg::CNT_MAX) inuse_d = inuse_q + 1'b1;
        end
      end
      fbfl_pkg::CMD_FREE: begin
        if (!in_range) begin
          sts_d = fbfl_pkg::STS_RANGE;
        end else begin
          head_d  = IW'(idx_q);
          empty_d = 1'b0;
          if (inuse_q != '0) inuse_d = inuse_q - 1'b1;
        end
      end
      fbfl_pkg::CMD_CLEAR: begin
        head_d  = '0;
        empty_d = 1'b0;
        inuse_d = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en = cmd_i.sweep_wr ||
            (cmd_i.commit && (cmd_q == fbfl_pkg::CMD_FREE) && in_range);
    if (cmd_i.sweep_wr) begin
      wr_addr = swp_q;
      wr_data = {(swp_nxt == swp_cnt_q), (swp_nxt < swp_cnt_q) ? IW'(swp_nxt) : IW'(0)};
    end else begin
      wr_addr = IW'(idx_q);
      wr_data = {empty_q, head_q};
    end
  end

  // link store: one write port, one registered read port at the head
  always_ff @(posedge clk_i) begin
    if (wr_en) link_mem[wr_addr] <= wr_data;
    if (cmd_i.accept) rd_q <= link_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_cnt_q   <= fbfl_pkg::BLK_CNT_RST;
      head_q      <= '0;
      empty_q     <= 1'b0;
      inuse_q     <= '0;
      swp_q       <= '0;
      swp_cnt_q   <= UW'(RstCnt);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) blk_cnt_q <= cfg_data_i;
      if (cmd_i.accept) begin
        swp_q     <= '0;
        swp_cnt_q <= used;
      end else if (cmd_i.sweep_wr) begin
        swp_q <= swp_q + 1'b1;
      end
      if (cmd_i.commit) begin
        head_q  <= head_d;
        empty_q <= empty_d;
        inuse_q <= inuse_d;
      end
      if (cmd_i.commit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= in_cmd_i;
      idx_q <= in_idx_i;
    end
    if (cmd_i.commit) begin
      out_status_q <= sts_d;
      out_idx_q    <= given_d;
      out_cnt_q    <= inuse_d;
    end
  end

  assign stat_o.in_clear   = (in_cmd_i == fbfl_pkg::CMD_CLEAR);
  assign stat_o.sweep_last = (swp_q == IW'(MAX_BLOCKS - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_idx_o    = out_idx_q;
  assign out_cnt_o    = out_cnt_q;

endmodule

>>> sv/fixed_block_free_list_allocator.sv
// top level of the fixed-size block free-list allocator
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid_i/tready_o     | tuser cmd, tdata free_index
//  m_axis    | out       | m_axis_tvalid_o/tready_i     | tuser status, tdata index+count
//  cfg       | in        | cfg_valid_i/cfg_ready_o      | cfg_data_i block_count
//
// allocate, free and unknown commands go through accept, then commit;
// allocate reads the head link from the registered read port of the link store
// clear adds a relink sweep between accept and commit, one entry relinked per cycle
// after reset a relink pass over all MAX_BLOCKS entries runs before the first transfer
// a result waits in the output register; commit stalls while it is full and not taken
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [9:0] free_index, rest zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [9:0] block_index, [20:10] in_use_count
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i        // block_count
);

  fbfl_pkg::fbfl_cmd_t  ctrl_cmd;
  fbfl_pkg::fbfl_stat_t dp_stat;

  logic [fbfl_pkg::IDX_W-1:0] out_idx;
  logic [fbfl_pkg::CNT_W-1:0] out_cnt;

  // config is always taken; the user must write it only while idle, it is not enforced
  assign cfg_ready_o = 1'b1;

  fbfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  fbfl_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat),
    .in_cmd_i     (s_axis_tuser_i),
    .in_idx_i     (s_axis_tdata_i[9:0]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (m_axis_tuser_o),
    .out_idx_o    (out_idx),
    .out_cnt_o    (out_cnt)
  );

  // pack result fields from the lowest bit up, zero padded to whole bytes
  assign m_axis_tdata_o = {3'b000, out_cnt, out_idx};

  // one item at a time: ready drops right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while an item is in progress");

  // a commit always lands in the output register
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.commit |=> m_axis_tvalid_o)
    else $error("committed result not presented");

  // no commit while a held result is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !ctrl_cmd.commit)
    else $error("result overwritten before transfer");

  // status code is never the unused one
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != fbfl_pkg::STS_BAD))
    else $error("unused status code on output");

endmodule
